/* hw/rtl/par_pkg.sv */
`default_nettype none
package par_pkg;

  // table size default
  localparam int SLOTS_DEF = 16;

  // configuration register indexes
  localparam logic [1:0] CFG_OWN_ID    = 2'd0;
  localparam logic [1:0] CFG_BCAST_ID  = 2'd1;
  localparam logic [1:0] CFG_RETRY_LIM = 2'd2;

  localparam logic [31:0] BCAST_RST = 32'hFFFF_FFFF;
  localparam logic [2:0]  RETRY_RST = 3'd5;

  // input function codes
  localparam logic [1:0] FUNC_SEND = 2'd0;
  localparam logic [1:0] FUNC_RECV = 2'd1;
  localparam logic [1:0] FUNC_POLL = 2'd2;

  // ack kinds
  localparam logic [1:0] ACK_PLAIN = 2'd0;
  localparam logic [1:0] ACK_REQ   = 2'd1;
  localparam logic [1:0] ACK_ACK   = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_TX    = 2'd0;
  localparam logic [1:0] KIND_RETX  = 2'd1;
  localparam logic [1:0] KIND_ACKTX = 2'd2;
  localparam logic [1:0] KIND_DELIV = 2'd3;

  // classified operations handed from front to back
  localparam logic [2:0] OP_SEND      = 3'd0;
  localparam logic [2:0] OP_STORE     = 3'd1;
  localparam logic [2:0] OP_ACK       = 3'd2;
  localparam logic [2:0] OP_DELIV     = 3'd3;
  localparam logic [2:0] OP_DELIV_ACK = 3'd4;
  localparam logic [2:0] OP_POLL      = 3'd5;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] dest;
    logic [31:0] src;
    logic [7:0]  cmd;
    logic [1:0]  ack;
  } par_entry_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] dest;
    logic [31:0] src;
    logic [7:0]  cmd;
    logic [1:0]  ack;
    logic        drop;
  } par_res_t;

endpackage
`default_nettype wire

/* hw/rtl/par_if.sv */
`default_nettype none
// input item channel
interface par_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] dest_id;
  logic [31:0] src_id;
  logic [7:0]  cmd;
  logic [1:0]  ack_kind;
  modport source (output valid, func, dest_id, src_id, cmd, ack_kind, input ready);
  modport sink   (input valid, func, dest_id, src_id, cmd, ack_kind, output ready);
endinterface

// result item channel
interface par_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] out_dest_id;
  logic [31:0] out_src_id;
  logic [7:0]  out_cmd;
  logic [1:0]  out_ack_kind;
  logic        dropped;
  logic        last;
  modport source (output valid, kind, out_dest_id, out_src_id, out_cmd, out_ack_kind,
                  dropped, last, input ready);
  modport sink   (input valid, kind, out_dest_id, out_src_id, out_cmd, out_ack_kind,
                  dropped, last, output ready);
endinterface

// configuration write channel
interface par_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/pending_ack_retransmit_table.sv */
// A send or delivery passes from the pending register to the output register, and a
// delivery that asks for an ack first gives an ack reply. A store, ack or poll scans
// the slots, each read and then checked, until a hit or the last slot. The back end
// takes no new item until it is through with the last, also while the output stalls;
// a two-entry queue and the output register let input and output stall independently.
// Reset (synchronous, rst_n low): all slots empty, queue and output cleared,
// own_id 0, broadcast_id all ones, retry_limit 5.
`default_nettype none
module pending_ack_retransmit_table
  import par_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
)
(
  input wire logic clk,
  input wire logic rst_n,
  par_in_if.sink     in_if,
  par_out_if.source  out_if,
  par_cfg_if.sink    cfg_if
);

  logic [31:0] own_id_r, bcast_id_r;
  logic [2:0]  retry_lim_r;
  logic        q_push, q_full, q_avail, q_pop;
  par_entry_t  push_entry, pop_entry;

  assign cfg_if.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r    <= '0;
      bcast_id_r  <= BCAST_RST;
      retry_lim_r <= RETRY_RST;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        CFG_OWN_ID:    own_id_r    <= cfg_if.data;
        CFG_BCAST_ID:  bcast_id_r  <= cfg_if.data;
        CFG_RETRY_LIM: retry_lim_r <= cfg_if.data[2:0];
        default:       ;
      endcase
    end
  end

  par_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .own_id   (own_id_r),
    .bcast_id (bcast_id_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (push_entry)
  );

  par_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .avail      (q_avail),
    .pop        (q_pop),
    .pop_entry  (pop_entry)
  );

  par_back #(.SLOTS(SLOTS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_avail     (q_avail),
    .q_entry     (pop_entry),
    .q_pop       (q_pop),
    .own_id      (own_id_r),
    .retry_limit (retry_lim_r),
    .out_if      (out_if)
  );

endmodule
`default_nettype wire

/* hw/rtl/par_front.sv */
`default_nettype none
module par_front
  import par_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  par_in_if.sink         in_if,
  input  wire logic [31:0] own_id,
  input  wire logic [31:0] bcast_id,
  input  wire logic      q_full,
  output logic           q_push,
  output par_entry_t     q_entry
);

  logic [1:0] ack_n;
  logic       keep;
  logic [2:0] op;
  logic       for_me;

  assign in_if.ready = rst_n && !q_full;

  // classify the item; items with no effect are dropped here
  always_comb begin
    ack_n  = (in_if.ack_kind == 2'd3) ? ACK_PLAIN : in_if.ack_kind;
    for_me = (in_if.dest_id == own_id);
    keep   = 1'b0;
    op     = OP_SEND;
    case (in_if.func)
      FUNC_SEND: begin
        keep = 1'b1;
        op   = (ack_n == ACK_REQ && in_if.cmd != 8'd0) ? OP_STORE : OP_SEND;
      end
      FUNC_RECV: begin
        if (for_me && ack_n == ACK_ACK) begin
          keep = 1'b1;
          op   = OP_ACK;
        end else if (for_me || in_if.dest_id == bcast_id) begin
          keep = 1'b1;
          op   = (ack_n == ACK_REQ) ? OP_DELIV_ACK : OP_DELIV;
        end
      end
      FUNC_POLL: begin
        keep = 1'b1;
        op   = OP_POLL;
      end
      default: keep = 1'b0;
    endcase
  end

  assign q_push        = in_if.valid && in_if.ready && keep;
  assign q_entry.op    = op;
  assign q_entry.dest  = in_if.dest_id;
  assign q_entry.src   = in_if.src_id;
  assign q_entry.cmd   = in_if.cmd;
  assign q_entry.ack   = ack_n;

  // clk only drives checks of the handshake gating
  a_push_gated: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("push into full queue");

endmodule
`default_nettype wire

/* hw/rtl/par_queue.sv */
`default_nettype none
module par_queue
  import par_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire par_entry_t push_entry,
  output logic       full,
  output logic       avail,
  input  wire logic  pop,
  output par_entry_t pop_entry
);

  par_entry_t  mem_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign avail     = (cnt_r != 2'd0);
  assign pop_entry = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_entry;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != 2'd0) else $error("queue underflow");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2) else $error("queue overflow");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 2'd1) else $error("count slip");

endmodule
`default_nettype wire

/* hw/rtl/par_back.sv */
`default_nettype none
module par_back
  import par_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
)
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_avail,
  input  wire par_entry_t  q_entry,
  output logic             q_pop,
  input  wire logic [31:0] own_id,
  input  wire logic [2:0]  retry_limit,
  par_out_if.source        out_if
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_OUTA = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  par_entry_t       ent_r;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [SLOTS-1:0] occ_r;

  // slot store, read one entry a cycle
  logic [7:0]  mem_cmd  [SLOTS];
  logic [31:0] mem_peer [SLOTS];
  logic [2:0]  mem_ret  [SLOTS];
  logic [7:0]  rd_cmd_r;
  logic [31:0] rd_peer_r;
  logic [2:0]  rd_ret_r;

  par_res_t pend_r, pend_nxt;
  par_res_t out_r, out_nxt;
  logic     out_valid_r, out_last_r, out_last_nxt;

  logic       pend_ld, out_ld, ent_ld;
  logic       slot_we, ret_we, occ_set, occ_clr;
  logic [2:0] ret_wdata, retry_eff;
  logic       hit, last_slot, out_free;

  assign retry_eff = (retry_limit == 3'd0) ? 3'd1 : retry_limit;
  assign last_slot = (idx_r == IDX_W'(SLOTS - 1));
  assign out_free  = !out_valid_r || out_if.ready;

  // slot match for the current operation
  always_comb begin
    case (ent_r.op)
      OP_STORE: hit = !occ_r[idx_r];
      OP_ACK:   hit = occ_r[idx_r] && rd_cmd_r == ent_r.cmd && rd_peer_r == ent_r.src;
      OP_POLL:  hit = occ_r[idx_r];
      default:  hit = 1'b0;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    q_pop        = 1'b0;
    ent_ld       = 1'b0;
    pend_ld      = 1'b0;
    pend_nxt     = pend_r;
    out_ld       = 1'b0;
    out_nxt      = out_r;
    out_last_nxt = 1'b1;
    slot_we      = 1'b0;
    ret_we       = 1'b0;
    ret_wdata    = rd_ret_r - 3'd1;
    occ_set      = 1'b0;
    occ_clr      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (q_avail) begin
          q_pop   = 1'b1;
          ent_ld  = 1'b1;
          idx_nxt = '0;
          pend_ld = 1'b1;
          pend_nxt = '{kind: KIND_TX, dest: q_entry.dest, src: own_id,
                       cmd: q_entry.cmd, ack: q_entry.ack, drop: 1'b0};
          case (q_entry.op)
            OP_SEND: state_nxt = S_OUT;
            OP_DELIV: begin
              pend_nxt = '{kind: KIND_DELIV, dest: q_entry.dest, src: q_entry.src,
                           cmd: q_entry.cmd, ack: q_entry.ack, drop: 1'b0};
              state_nxt = S_OUT;
            end
            OP_DELIV_ACK: begin
              pend_nxt = '{kind: KIND_DELIV, dest: q_entry.dest, src: q_entry.src,
                           cmd: q_entry.cmd, ack: q_entry.ack, drop: 1'b0};
              state_nxt = S_OUTA;
            end
            default: state_nxt = S_RD;
          endcase
        end
      end
      S_RD: state_nxt = S_CHK;
      S_CHK: begin
        if (hit) begin
          case (ent_r.op)
            OP_STORE: begin
              slot_we   = 1'b1;
              occ_set   = 1'b1;
              state_nxt = S_OUT;
            end
            OP_ACK: begin
              occ_clr   = 1'b1;
              state_nxt = S_IDLE;
            end
            default: begin
              pend_ld  = 1'b1;
              pend_nxt = '{kind: KIND_RETX, dest: rd_peer_r, src: own_id,
                           cmd: rd_cmd_r, ack: ACK_REQ, drop: 1'b0};
              if (rd_ret_r <= 3'd1) occ_clr = 1'b1;
              else ret_we = 1'b1;
              state_nxt = S_OUT;
            end
          endcase
        end else if (last_slot) begin
          if (ent_r.op == OP_STORE) begin
            pend_ld       = 1'b1;
            pend_nxt.drop = 1'b1;
            state_nxt     = S_OUT;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = S_RD;
        end
      end
      S_OUTA: begin
        if (out_free) begin
          out_ld       = 1'b1;
          out_nxt      = '{kind: KIND_ACKTX, dest: ent_r.src, src: own_id,
                           cmd: ent_r.cmd, ack: ACK_ACK, drop: 1'b0};
          out_last_nxt = 1'b0;
          state_nxt    = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_ld    = 1'b1;
          out_nxt   = pend_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // slot store and registered read
  always_ff @(posedge clk) begin
    if (slot_we) begin
      mem_cmd[idx_r]  <= ent_r.cmd;
      mem_peer[idx_r] <= ent_r.dest;
      mem_ret[idx_r]  <= retry_eff;
    end else if (ret_we) begin
      mem_ret[idx_r] <= ret_wdata;
    end
    rd_cmd_r  <= mem_cmd[idx_r];
    rd_peer_r <= mem_peer[idx_r];
    rd_ret_r  <= mem_ret[idx_r];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ent_ld)  ent_r <= q_entry;
    if (pend_ld) pend_r <= pend_nxt;
    if (out_ld) begin
      out_r      <= out_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      if (occ_set) occ_r[idx_r] <= 1'b1;
      if (occ_clr) occ_r[idx_r] <= 1'b0;
      if (out_ld) out_valid_r <= 1'b1;
      else if (out_if.ready) out_valid_r <= 1'b0;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.kind         = out_r.kind;
  assign out_if.out_dest_id  = out_r.dest;
  assign out_if.out_src_id   = out_r.src;
  assign out_if.out_cmd      = out_r.cmd;
  assign out_if.out_ack_kind = out_r.ack;
  assign out_if.dropped      = out_r.drop;
  assign out_if.last         = out_last_r;

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == S_IDLE) else $error("pop while busy");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_ld |-> (!out_valid_r || out_if.ready)) else $error("result overwritten");
  a_empty_after_rst: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> occ_r == '0) else $error("slots not empty after reset");
  a_set_free: assert property (@(posedge clk) disable iff (!rst_n)
    occ_set |-> !occ_r[idx_r]) else $error("store into occupied slot");

endmodule
`default_nettype wire
